[hdl/bgic_pkg.sv]
// Shared types, constants and helper functions of the green imbalance corrector.
`default_nettype none

package bgic_pkg;

    localparam int PixW     = 8;
    localparam int PosW     = 12;
    localparam int SumW     = 10;
    localparam int SpreadW  = 11;
    localparam int NumW     = 18;
    localparam int QuotW    = 9;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 13;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_BRIGHT_LIMIT = 2'd0,
        CFG_FLAT_LIMIT   = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [PixW-1:0] center_pixel;
        logic [PixW-1:0] diag_up_left;
        logic [PixW-1:0] diag_up_right;
        logic [PixW-1:0] diag_down_left;
        logic [PixW-1:0] diag_down_right;
        logic [PixW-1:0] cross_up;
        logic [PixW-1:0] cross_down;
        logic [PixW-1:0] cross_left;
        logic [PixW-1:0] cross_right;
        logic [PosW-1:0] row_index;
        logic [PosW-1:0] col_index;
    } t_in_item;

    typedef struct packed {
        logic [PixW-1:0] pixel_out;
        logic            was_corrected;
    } t_out_item;

    typedef struct packed {
        logic [8:0]          bright_limit;
        logic [SpreadW-1:0]  flat_limit;
        logic [CfgDataW-1:0] image_width;
        logic [CfgDataW-1:0] image_height;
    } t_cfg;

    // Data that travels down the divider chain.
    typedef struct packed {
        logic [PixW-1:0]  pixel;
        logic             corr;
        logic [NumW-1:0]  rem;
        logic [SumW-1:0]  divisor;
        logic [QuotW-1:0] quot;
    } t_div_data;

    function automatic logic [PixW-1:0] absdiff(input logic [PixW-1:0] a,
                                                input logic [PixW-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [SpreadW-1:0] spread6(input logic [PixW-1:0] a,
                                                   input logic [PixW-1:0] b,
                                                   input logic [PixW-1:0] c,
                                                   input logic [PixW-1:0] d);
        return SpreadW'(absdiff(a, b)) + SpreadW'(absdiff(a, c))
             + SpreadW'(absdiff(a, d)) + SpreadW'(absdiff(b, c))
             + SpreadW'(absdiff(c, d)) + SpreadW'(absdiff(b, d));
    endfunction

endpackage

`default_nettype wire

[hdl/bgic_front.sv]
// Front stage: site, brightness and flatness tests, sums and the numerator product.
`default_nettype none

module bgic_front #(
    parameter int MAX_SIDE = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire bgic_pkg::t_in_item i_data,
    input  wire bgic_pkg::t_cfg     i_cfg,
    output logic                    o_ready,
    output logic                    o_valid,
    output bgic_pkg::t_div_data     o_data,
    input  wire logic               i_ready
);
    import bgic_pkg::*;

    localparam int SideW = $clog2(MAX_SIDE + 1);
    localparam int CmpW  = (SideW > CfgDataW) ? SideW : CfgDataW;
    localparam logic [CmpW-1:0] MaxSide = CmpW'(MAX_SIDE);

    logic            r_valid;
    t_div_data       r_data;
    t_div_data       n_data;
    logic [CmpW-1:0] w_width;
    logic [CmpW-1:0] w_height;
    logic            w_row_ok;
    logic            w_col_ok;
    logic            w_bright_ok;
    logic            w_flat_ok;
    logic [SumW-1:0] w_dsum;
    logic [SumW-1:0] w_csum;
    logic [NumW-1:0] w_num;

    always_comb begin
        w_width  = (CmpW'(i_cfg.image_width) > MaxSide) ? MaxSide : CmpW'(i_cfg.image_width);
        w_height = (CmpW'(i_cfg.image_height) > MaxSide) ? MaxSide
                                                         : CmpW'(i_cfg.image_height);
        w_row_ok = !i_data.row_index[0] && (i_data.row_index >= PosW'(2))
                && ((CmpW'(i_data.row_index) + CmpW'(3)) < w_height);
        w_col_ok = i_data.col_index[0] && (i_data.col_index >= PosW'(3))
                && ((CmpW'(i_data.col_index) + CmpW'(3)) < w_width);
        w_bright_ok = {1'b0, i_data.center_pixel} < i_cfg.bright_limit;
        w_flat_ok = (spread6(i_data.diag_up_left, i_data.diag_up_right,
                             i_data.diag_down_left, i_data.diag_down_right) < i_cfg.flat_limit)
                 && (spread6(i_data.cross_up, i_data.cross_down,
                             i_data.cross_left, i_data.cross_right) < i_cfg.flat_limit);
        w_dsum = SumW'(i_data.diag_up_left) + SumW'(i_data.diag_up_right)
               + SumW'(i_data.diag_down_left) + SumW'(i_data.diag_down_right);
        w_csum = SumW'(i_data.cross_up) + SumW'(i_data.cross_down)
               + SumW'(i_data.cross_left) + SumW'(i_data.cross_right);
        w_num  = NumW'(i_data.center_pixel) * NumW'(w_dsum);

        n_data.pixel = i_data.center_pixel;
        n_data.corr  = w_row_ok && w_col_ok && w_bright_ok && w_flat_ok;
        n_data.rem   = w_num;
        // A zero numerator always gives zero; a divisor of one gets there
        // even when the cross sum is zero. A zero cross sum with a nonzero
        // numerator passes every compare and so saturates.
        n_data.divisor = (w_num == '0) ? SumW'(1) : w_csum;
        n_data.quot    = '0;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

[hdl/bgic_div_cell.sv]
// One restoring-division cell: decides one quotient bit and hands on the remainder.
`default_nettype none

module bgic_div_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire bgic_pkg::t_div_data i_data,
    output logic                     o_ready,
    output logic                     o_valid,
    output bgic_pkg::t_div_data      o_data,
    input  wire logic                i_ready
);
    import bgic_pkg::*;

    logic            r_valid;
    t_div_data       r_data;
    t_div_data       n_data;
    logic [NumW:0]   w_shifted;
    logic [NumW:0]   w_diff;

    always_comb begin
        w_shifted = (NumW + 1)'(i_data.divisor) << SHIFT;
        w_diff    = {1'b0, i_data.rem} - w_shifted;
        n_data    = i_data;
        if (!w_diff[NumW]) begin
            n_data.rem         = w_diff[NumW-1:0];
            n_data.quot[SHIFT] = 1'b1;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

[hdl/bayer_green_imbalance_correct.sv]
// Top level of the Bayer green imbalance corrector: front stage, divider chain, output register.
//
// The input channel takes one item per clock while o_in_stall is low: a center pixel, its
// four diagonal and four distance-two neighbors, and its row and column. An item is
// accepted on a rising edge where i_in_valid is high and o_in_stall is low. The output
// channel returns one item per input item, in order, under the same valid/stall rule with
// i_out_stall. Before o_out_valid rises, an accepted item passes through these registered
// stages in order: one front stage that tests the site, brightness and flatness and forms
// the product pixel times diagonal sum, nine division cells (one saturation test and eight
// quotient bits, one bit per cell) and the output register. Throughput is one item per
// clock while no stall holds the chain; every stage has its own valid bit, so bubbles
// close up and a new item is taken while a finished one waits. When the receiver stalls,
// the chain fills up and o_in_stall rises only once no stage is free. Reset (synchronous,
// active low) empties every stage and loads the register defaults: bright limit 243, flat
// limit 62, width 1920, height 1080. Registers are written through
// i_cfg_we/i_cfg_index/i_cfg_data while the block is idle.
`default_nettype none

module bayer_green_imbalance_correct #(
    parameter int MAX_SIDE = 4096
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    input  wire bgic_pkg::t_in_item                  i_in_data,
    output logic                                     o_in_stall,
    output logic                                     o_out_valid,
    output bgic_pkg::t_out_item                      o_out_data,
    input  wire logic                                i_out_stall,
    input  wire logic                                i_cfg_we,
    input  wire logic [bgic_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  wire logic [bgic_pkg::CfgDataW-1:0]       i_cfg_data
);
    import bgic_pkg::*;

    // One saturation cell (quotient of 256 or more) plus one cell per result bit.
    localparam int NumCells = QuotW;

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item n_out_data;

    // Stage 0 is the front stage; stage k is the output of cell k.
    logic      s_valid [0:NumCells];
    t_div_data s_data  [0:NumCells];
    logic      s_ready [0:NumCells];
    logic      w_front_ready;
    logic      w_out_ready;

    // Configuration registers. Writes are expected only while the chain is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bright_limit <= 9'd243;
            r_cfg.flat_limit   <= SpreadW'(62);
            r_cfg.image_width  <= CfgDataW'(1920);
            r_cfg.image_height <= CfgDataW'(1080);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_BRIGHT_LIMIT: r_cfg.bright_limit <= i_cfg_data[8:0];
                CFG_FLAT_LIMIT:   r_cfg.flat_limit   <= i_cfg_data[SpreadW-1:0];
                CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bgic_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (r_cfg),
        .o_ready (w_front_ready),
        .o_valid (s_valid[0]),
        .o_data  (s_data[0]),
        .i_ready (s_ready[0])
    );

    assign o_in_stall = !w_front_ready;

    // The first cell tests against the divisor shifted by eight, which flags a
    // quotient that does not fit in eight bits; the rest produce bits 7 down to 0.
    for (genvar k = 1; k <= NumCells; k++) begin : g_cell
        bgic_div_cell #(
            .SHIFT (NumCells - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k-1]),
            .i_data  (s_data[k-1]),
            .o_ready (s_ready[k-1]),
            .o_valid (s_valid[k]),
            .o_data  (s_data[k]),
            .i_ready (s_ready[k])
        );
    end

    assign w_out_ready        = !r_out_valid || !i_out_stall;
    assign s_ready[NumCells]  = w_out_ready;

    // Pick the passed-through pixel, the saturated value or the quotient.
    always_comb begin
        n_out_data.was_corrected = s_data[NumCells].corr;
        if (!s_data[NumCells].corr) begin
            n_out_data.pixel_out = s_data[NumCells].pixel;
        end else if (s_data[NumCells].quot[QuotW-1]) begin
            n_out_data.pixel_out = {PixW{1'b1}};
        end else begin
            n_out_data.pixel_out = s_data[NumCells].quot[PixW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= s_valid[NumCells];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && s_valid[NumCells]) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the Bayer green imbalance corrector.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bgic_pkg::*;

    // Frame sides above this are treated as this size by the block.
    localparam int unsigned SideCap = 4096;
    // Cycles with no item accepted on either channel before the run is abandoned.
    localparam int unsigned StallLimit = 2000;
    // Pause after the last result before the registers are touched again.
    localparam int unsigned SettleCycles = 12;
    localparam int NumDirected = 21;
    localparam int NumPhases = 7;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    t_in_item            i_in_data = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out_item           o_out_data;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    bayer_green_imbalance_correct DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // The testbench's own copy of the four registers, loaded with the reset values.
    logic [8:0]  bright_lim = 9'd243;
    logic [10:0] flat_lim = 11'd62;
    logic [12:0] img_w = 13'd1920;
    logic [12:0] img_h = 13'd1080;

    // Results still owed by the block, oldest first.
    t_out_item expected_pixels[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    // When set, neither side idles: the pipeline runs at full rate.
    bit steady_flow = 1'b0;

    // One directed item. The diagonal set packs up-left, up-right, down-left and
    // down-right from the top byte down; the cross set packs up, down, left, right.
    typedef struct {
        logic [7:0]  center;
        logic [31:0] diag;
        logic [31:0] cross_set;
        logic [11:0] row;
        logic [11:0] col;
        bit          typed;
        logic [7:0]  exp_pixel;
        bit          exp_corr;
    } t_stim_row;

    // All rows assume the reset register values: bright limit 243, flat limit 62,
    // and a 1920 by 1080 frame. Rows without a typed result go to the predictor.
    t_stim_row directed_rows [NumDirected] = '{
        // The frame origin is never a correctable site.
        '{8'd0,   32'h00000000, 32'h00000000, 12'd0,    12'd0,    1'b1, 8'd0,   1'b0},
        // Every bit set: far outside the frame, pixel passes.
        '{8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 12'hFFF,  12'hFFF,  1'b1, 8'd255, 1'b0},
        // First site in the frame with equal sums leaves the pixel as it is.
        '{8'd100, 32'h64646464, 32'h64646464, 12'd2,    12'd3,    1'b1, 8'd100, 1'b1},
        // Zero cross sum with a nonzero product saturates.
        '{8'd100, 32'h0A0A0A0A, 32'h00000000, 12'd2,    12'd3,    1'b1, 8'd255, 1'b1},
        // Zero cross sum with a zero product gives zero.
        '{8'd0,   32'h0A0A0A0A, 32'h00000000, 12'd4,    12'd5,    1'b1, 8'd0,   1'b1},
        // A ratio of four would give 800, which saturates.
        '{8'd200, 32'h28282828, 32'h0A0A0A0A, 12'd2,    12'd3,    1'b1, 8'd255, 1'b1},
        // A pixel equal to the brightness limit is left alone; one below is corrected.
        '{8'd243, 32'h64646464, 32'h64646464, 12'd2,    12'd3,    1'b1, 8'd243, 1'b0},
        '{8'd242, 32'h64646464, 32'h64646464, 12'd2,    12'd3,    1'b1, 8'd242, 1'b1},
        // Odd row, even column, top row and left columns are not sites.
        '{8'd100, 32'h64646464, 32'h64646464, 12'd3,    12'd3,    1'b1, 8'd100, 1'b0},
        '{8'd100, 32'h64646464, 32'h64646464, 12'd2,    12'd4,    1'b1, 8'd100, 1'b0},
        '{8'd100, 32'h64646464, 32'h64646464, 12'd0,    12'd3,    1'b1, 8'd100, 1'b0},
        '{8'd100, 32'h64646464, 32'h64646464, 12'd2,    12'd1,    1'b1, 8'd100, 1'b0},
        // Last site before the bottom right corner, then one step past each border.
        '{8'd100, 32'h64646464, 32'h64646464, 12'd1076, 12'd1915, 1'b1, 8'd100, 1'b1},
        '{8'd100, 32'h64646464, 32'h64646464, 12'd1078, 12'd3,    1'b1, 8'd100, 1'b0},
        '{8'd100, 32'h64646464, 32'h64646464, 12'd2,    12'd1917, 1'b1, 8'd100, 1'b0},
        // Diagonal spread of 60 is just flat enough; 63 is not.
        '{8'd100, 32'h0A0A0A1E, 32'h14141414, 12'd2,    12'd3,    1'b0, 8'd0,   1'b0},
        '{8'd100, 32'h0A0A0A1F, 32'h14141414, 12'd2,    12'd3,    1'b0, 8'd0,   1'b0},
        // The cross set fails flatness on its own.
        '{8'd100, 32'h14141414, 32'h14141429, 12'd2,    12'd3,    1'b0, 8'd0,   1'b0},
        // Checkerboard diagonals are as uneven as they get.
        '{8'd50,  32'h00FF00FF, 32'h32323232, 12'd2,    12'd3,    1'b0, 8'd0,   1'b0},
        // An ordinary mid-frame site with slightly uneven neighbors.
        '{8'd37,  32'h30322F31, 32'h2E332D30, 12'd100,  12'd201,  1'b0, 8'd0,   1'b0},
        // Largest diagonal sum against the smallest nonzero cross sum lands on 255.
        '{8'd1,   32'hFFFFFFFF, 32'h01010101, 12'd2,    12'd3,    1'b0, 8'd0,   1'b0}
    };

    // Register settings for each run phase. The first phase keeps the reset values
    // and is never written; the shuffled phase draws every register at random.
    typedef struct {
        logic [12:0] bright;
        logic [12:0] flat;
        logic [12:0] width;
        logic [12:0] height;
        int          items;
        bit          steady;
        bit          shuffle;
    } t_phase;

    t_phase phases [NumPhases] = '{
        '{13'd243, 13'd62,   13'd1920, 13'd1080, 150, 1'b0, 1'b0},
        // Widest limits and the largest frame the block knows.
        '{13'd256, 13'd1531, 13'd4096, 13'd4096, 150, 1'b0, 1'b0},
        // Zero limits and a one-pixel frame: nothing can be corrected.
        '{13'd0,   13'd0,    13'd1,    13'd1,    60,  1'b0, 1'b0},
        // A tiny frame with only a handful of sites.
        '{13'd243, 13'd1531, 13'd8,    13'd8,    100, 1'b0, 1'b0},
        // Oversized sides that must be cut back, with the tightest useful limits.
        '{13'd1,   13'd1,    13'd8191, 13'd8191, 80,  1'b0, 1'b0},
        '{13'd0,   13'd0,    13'd0,    13'd0,    150, 1'b0, 1'b1},
        // A long stretch at full rate on both sides.
        '{13'd200, 13'd700,  13'd1920, 13'd1080, 150, 1'b1, 1'b0}
    };

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Sum of absolute differences over all six pairs of a packed set of four pixels.
    function automatic int unsigned set_spread(input logic [31:0] quad);
        int unsigned v [4];
        int unsigned total;
        total = 0;
        for (int i = 0; i < 4; i++) begin
            v[i] = 32'(quad[8*i +: 8]);
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = i + 1; j < 4; j++) begin
                total += (v[i] > v[j]) ? v[i] - v[j] : v[j] - v[i];
            end
        end
        return total;
    endfunction

    // Works out the corrected pixel for one item under the current register copy.
    function automatic t_out_item predict_green_fix(input t_in_item x);
        int unsigned w, h, row, col, dsum, csum, num, quot;
        logic [31:0] diag, cross_set;
        bit on_site, flat;
        t_out_item r;
        w = (img_w > SideCap) ? SideCap : 32'(img_w);
        h = (img_h > SideCap) ? SideCap : 32'(img_h);
        row = 32'(x.row_index);
        col = 32'(x.col_index);
        diag = {x.diag_up_left, x.diag_up_right, x.diag_down_left, x.diag_down_right};
        cross_set = {x.cross_up, x.cross_down, x.cross_left, x.cross_right};
        // Green sites of interest sit on even rows and odd columns, two pixels clear of
        // the top edge and three clear of the left, bottom and right edges.
        on_site = !row[0] && row >= 2 && row + 3 < h && col[0] && col >= 3 && col + 3 < w;
        flat = set_spread(diag) < flat_lim && set_spread(cross_set) < flat_lim;
        r.pixel_out = x.center_pixel;
        r.was_corrected = 1'b0;
        if (on_site && x.center_pixel < bright_lim && flat) begin
            dsum = 0;
            csum = 0;
            for (int k = 0; k < 4; k++) begin
                dsum += 32'(diag[8*k +: 8]);
                csum += 32'(cross_set[8*k +: 8]);
            end
            num = 32'(x.center_pixel) * dsum;
            // A zero divisor is taken as an infinite ratio unless there is nothing
            // to scale.
            if (csum == 0) begin
                quot = (num == 0) ? 0 : 255;
            end else begin
                quot = num / csum;
            end
            r.pixel_out = (quot > 255) ? 8'd255 : quot[7:0];
            r.was_corrected = 1'b1;
        end
        return r;
    endfunction

    // Four pixels scattered around a common base by at most the given amount.
    function automatic logic [31:0] flat_quad(input int unsigned jitter);
        int base, v;
        logic [31:0] q;
        base = int'($urandom_range(0, 255));
        for (int k = 0; k < 4; k++) begin
            v = base + int'($urandom_range(0, 2 * jitter)) - int'(jitter);
            v = (v < 0) ? 0 : (v > 255) ? 255 : v;
            q[8*k +: 8] = v[7:0];
        end
        return q;
    endfunction

    // A row or column that lands near a frame border or anywhere inside the frame,
    // mostly with the parity that green sites need.
    function automatic logic [11:0] pick_coord(input int unsigned span, input bit odd);
        int unsigned c;
        case ($urandom_range(0, 3))
            0: begin
                c = $urandom_range(0, 8);
            end
            1: begin
                c = (span > 8) ? span - $urandom_range(1, 8) : $urandom_range(0, 8);
            end
            default: begin
                c = $urandom_range(0, (span > 1) ? span - 1 : 0);
            end
        endcase
        if ($urandom_range(0, 9) != 0) begin
            c[0] = odd;
        end
        return c[11:0];
    endfunction

    // Most items are flat windows on likely sites with random content, so the
    // division path is well exercised; the rest are plain noise.
    function automatic t_in_item random_window();
        t_in_item x;
        int unsigned jitter;
        int near;
        x = {$urandom, $urandom, $urandom};
        if ($urandom_range(0, 99) < 75) begin
            case ($urandom_range(0, 3))
                0: jitter = 0;
                3: jitter = $urandom_range(0, 40);
                default: jitter = $urandom_range(0, 8);
            endcase
            {x.diag_up_left, x.diag_up_right, x.diag_down_left, x.diag_down_right} =
                flat_quad(jitter);
            {x.cross_up, x.cross_down, x.cross_left, x.cross_right} =
                ($urandom_range(0, 49) == 0) ? 32'h0 : flat_quad(jitter);
            x.row_index = pick_coord((img_h > SideCap) ? SideCap : 32'(img_h), 1'b0);
            x.col_index = pick_coord((img_w > SideCap) ? SideCap : 32'(img_w), 1'b1);
            // Now and then probe the pixel right at the brightness limit.
            if ($urandom_range(0, 3) == 0) begin
                near = int'(bright_lim) - 1 + int'($urandom_range(0, 1));
                x.center_pixel = (near < 0) ? 8'd0 : (near > 255) ? 8'd255 : near[7:0];
            end
        end
        return x;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Offers one item and waits until the block takes it, then records what it owes.
    // Valid stays high into the next item unless the sender decides to idle.
    task automatic send_window(input t_in_item x, input bit typed, input t_out_item typed_out);
        i_in_valid <= 1'b1;
        i_in_data <= x;
        do @(posedge i_clk); while (o_in_stall);
        expected_pixels.push_back(typed ? typed_out : predict_green_fix(x));
        if (!steady_flow && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Stops offering items until every owed result has come back, then lets the
    // pipeline settle.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_pixels.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Writes all four registers in index order, one per clock, and updates the copy.
    task automatic load_registers(input logic [12:0] bright, input logic [12:0] flat,
                                  input logic [12:0] width, input logic [12:0] height);
        t_cfg_index idx;
        logic [12:0] vals [4];
        vals = '{bright, flat, width, height};
        idx = CFG_BRIGHT_LIMIT;
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            idx = idx.next();
        end
        i_cfg_we <= 1'b0;
        // Bits above a register's width are dropped.
        bright_lim = bright[8:0];
        flat_lim = flat[10:0];
        img_w = width;
        img_h = height;
    endtask

    // Result side: check each accepted item against the oldest expectation, then
    // pick the stall for the next cycle.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(o_out_data.pixel_out), 0);
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_data.pixel_out !== want.pixel_out) begin
                    report_mismatch("pixel_out", 32'(o_out_data.pixel_out),
                                    32'(want.pixel_out));
                end
                if (o_out_data.was_corrected !== want.was_corrected) begin
                    report_mismatch("was_corrected", 32'(o_out_data.was_corrected),
                                    32'(want.was_corrected));
                end
            end
        end
        i_out_stall <= !steady_flow && ($urandom_range(0, 99) < 25);
    end

    // Watchdog: abandon the run if the block stops moving items on both channels.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= StallLimit) begin
                $display("%0t: no item moved for %0d cycles", $time, StallLimit);
                $display("[bayer_green_imbalance_correct] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        t_in_item x;
        t_stim_row row;
        t_phase ph;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NumPhases; p++) begin
            ph = phases[p];
            if (p > 0) begin
                drain_pipeline();
                if (ph.shuffle) begin
                    load_registers(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                                   13'($urandom_range(1, 8191)), 13'($urandom_range(1, 8191)));
                end else begin
                    load_registers(ph.bright, ph.flat, ph.width, ph.height);
                end
            end
            steady_flow <= ph.steady;

            // The directed rows run once, straight after reset.
            if (p == 0) begin
                for (int k = 0; k < NumDirected; k++) begin
                    row = directed_rows[k];
                    x = '0;
                    x.center_pixel = row.center;
                    {x.diag_up_left, x.diag_up_right, x.diag_down_left,
                     x.diag_down_right} = row.diag;
                    {x.cross_up, x.cross_down, x.cross_left, x.cross_right} = row.cross_set;
                    x.row_index = row.row;
                    x.col_index = row.col;
                    send_window(x, row.typed, {row.exp_pixel, row.exp_corr});
                end
            end

            for (int i = 0; i < ph.items; i++) begin
                // Halfway through the second phase the sender holds off until the
                // block has handed back everything it took.
                if (p == 1 && i == ph.items / 2) begin
                    drain_pipeline();
                end
                send_window(random_window(), 1'b0, '0);
            end
        end

        drain_pipeline();
        if (expected_pixels.size() != 0) begin
            report_mismatch("results left pending", 32'(expected_pixels.size()), 0);
        end
        if (mismatch_count == 0) begin
            $display("[bayer_green_imbalance_correct] OK");
        end else begin
            $display("[bayer_green_imbalance_correct] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hdl/bgic_pkg.sv
hdl/bgic_front.sv
hdl/bgic_div_cell.sv
hdl/bayer_green_imbalance_correct.sv
tb/tb.sv
